// ===== hdl/ifdd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifdd_pkg: shared types and constants of the frame deframer/destuffer
// Register map, result kinds, receiver states and the word token that moves
// from the classifier to the frame engine.
// ----------------------------------------------------------------------------
package ifdd_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int CNT_W       = 11;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int PADDR_W     = 5;
    localparam int REG_IDX_W   = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FLAG      = 3'd0,
        REG_ESCAPE    = 3'd1,
        REG_STUFF_FLG = 3'd2,
        REG_STUFF_ESC = 3'd3,
        REG_ADDRESS   = 3'd4,
        REG_CTRL0     = 3'd5,
        REG_CTRL1     = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_GOOD      = 3'd1,
        KIND_CHECK_ERR = 3'd2,
        KIND_ESC_ERR   = 3'd3,
        KIND_OVERFLOW  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_FLAG = 3'd1,
        ST_ADDR = 3'd2,
        ST_CTRL = 3'd3,
        ST_DATA = 3'd4
    } rx_state_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_ESC  = 2'd1,
        ERR_OVF  = 2'd2
    } err_t;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] stuffed_flag_code;
        logic [7:0] stuffed_escape_code;
        logic [7:0] address_byte;
        logic [7:0] control_seq0;
        logic [7:0] control_seq1;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_flag;
        logic       is_esc;
        logic       is_addr;
        logic       is_ctrl0;
        logic       is_ctrl1;
        logic       is_hcs0;
        logic       is_hcs1;
        logic       is_sfc;
        logic       is_sec;
    } token_t;

endpackage
`default_nettype wire

// ===== hdl/info_frame_deframer_destuffer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one received word per cycle while m_ready is held high; result stalls fill the queue.
// An accepted word is registered in the token queue; the output register loads its result
//   as the word leaves the queue.
// A payload word is released by the following data word; the closing flag releases status.
// Reset: synchronous, active low; registers return to defaults, queue empties, hunt restarts.
// ----------------------------------------------------------------------------
// info_frame_deframer_destuffer_core: byte-stuffed information frame receiver
// Front classifier, 4-entry token queue and frame engine with an output
// register, plus the APB-style configuration register file.
// ----------------------------------------------------------------------------
module info_frame_deframer_destuffer_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ifdd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    // received words
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [7:0]                   s_rx_byte,
    // results
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [7:0]                        m_out_byte,
    output logic [2:0]                        m_kind,
    output logic                              m_seq_bit,
    output logic [ifdd_pkg::CNT_W-1:0]        m_frame_len
);
    import ifdd_pkg::*;

    cfg_t   cfg;
    token_t push_token;
    token_t pop_token;
    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_not_empty;

    // Configuration registers; the user must write them only while the receiver is idle (not enforced here)
    ifdd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: accept a word whenever the queue has room, tag it with its matches
    ifdd_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .cfg       (cfg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_token   (push_token)
    );

    // Queue: let the front keep accepting while the back waits on m_ready
    ifdd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_token),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_token),
        .not_empty (q_not_empty)
    );

    // Back: header hunt, destuffing, check-word holdback, status on close
    ifdd_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_valid     (q_not_empty),
        .q_token     (pop_token),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_kind      (m_kind),
        .m_seq_bit   (m_seq_bit),
        .m_frame_len (m_frame_len)
    );

endmodule
`default_nettype wire

// ===== hdl/ifdd_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifdd_regs: configuration register file
// APB-style slave holding the delimiter, escape and header match bytes.
// ----------------------------------------------------------------------------
module ifdd_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ifdd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output ifdd_pkg::cfg_t                  cfg
);
    import ifdd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_FLAG:      cfg_next.flag_byte           = pwdata[7:0];
                REG_ESCAPE:    cfg_next.escape_byte         = pwdata[7:0];
                REG_STUFF_FLG: cfg_next.stuffed_flag_code   = pwdata[7:0];
                REG_STUFF_ESC: cfg_next.stuffed_escape_code = pwdata[7:0];
                REG_ADDRESS:   cfg_next.address_byte        = pwdata[7:0];
                REG_CTRL0:     cfg_next.control_seq0        = pwdata[7:0];
                REG_CTRL1:     cfg_next.control_seq1        = pwdata[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte           <= 8'h7e;
            cfg_reg.escape_byte         <= 8'h7d;
            cfg_reg.stuffed_flag_code   <= 8'h5e;
            cfg_reg.stuffed_escape_code <= 8'h5d;
            cfg_reg.address_byte        <= 8'h03;
            cfg_reg.control_seq0        <= 8'h00;
            cfg_reg.control_seq1        <= 8'h40;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_FLAG:      prdata = {24'd0, cfg_reg.flag_byte};
            REG_ESCAPE:    prdata = {24'd0, cfg_reg.escape_byte};
            REG_STUFF_FLG: prdata = {24'd0, cfg_reg.stuffed_flag_code};
            REG_STUFF_ESC: prdata = {24'd0, cfg_reg.stuffed_escape_code};
            REG_ADDRESS:   prdata = {24'd0, cfg_reg.address_byte};
            REG_CTRL0:     prdata = {24'd0, cfg_reg.control_seq0};
            REG_CTRL1:     prdata = {24'd0, cfg_reg.control_seq1};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hdl/ifdd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifdd_front: input word classifier
// Compares each received word against the configured codes and pushes the
// word with its match flags into the token queue.
// ----------------------------------------------------------------------------
module ifdd_front (
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_rx_byte,
    input  wire ifdd_pkg::cfg_t cfg,
    input  wire logic           q_full,
    output logic                q_push,
    output ifdd_pkg::token_t    q_token
);
    import ifdd_pkg::*;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_token.data     = s_rx_byte;
        q_token.is_flag  = (s_rx_byte == cfg.flag_byte);
        q_token.is_esc   = (s_rx_byte == cfg.escape_byte);
        q_token.is_addr  = (s_rx_byte == cfg.address_byte);
        q_token.is_ctrl0 = (s_rx_byte == cfg.control_seq0);
        q_token.is_ctrl1 = (s_rx_byte == cfg.control_seq1);
        q_token.is_hcs0  = (s_rx_byte == (cfg.address_byte ^ cfg.control_seq0));
        q_token.is_hcs1  = (s_rx_byte == (cfg.address_byte ^ cfg.control_seq1));
        q_token.is_sfc   = (s_rx_byte == cfg.stuffed_flag_code);
        q_token.is_sec   = (s_rx_byte == cfg.stuffed_escape_code);
    end

endmodule
`default_nettype wire

// ===== hdl/ifdd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifdd_queue: token queue
// Short FIFO that decouples the classifier from the frame engine.
// ----------------------------------------------------------------------------
module ifdd_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire ifdd_pkg::token_t push_data,
    output logic                  full,
    input  wire logic             pop,
    output ifdd_pkg::token_t      pop_data,
    output logic                  not_empty
);
    import ifdd_pkg::*;

    token_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ifdd_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifdd_engine: frame engine
// Runs the header hunt, destuffs payload, holds back the check word and
// issues payload and status results through an output register.
// ----------------------------------------------------------------------------
module ifdd_engine (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ifdd_pkg::cfg_t   cfg,
    input  wire logic             q_valid,
    input  wire ifdd_pkg::token_t q_token,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_byte,
    output logic [2:0]            m_kind,
    output logic                  m_seq_bit,
    output logic [ifdd_pkg::CNT_W-1:0] m_frame_len
);
    import ifdd_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

    rx_state_t         state_reg, state_next;
    logic              esc_pend_reg, esc_pend_next;
    logic              seq_reg, seq_next;
    logic              held_valid_reg, held_valid_next;
    logic [7:0]        held_byte_reg, held_byte_next;
    logic [7:0]        xor_reg, xor_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    err_t              err_reg, err_next;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    kind_t             kind_reg, kind_next;
    logic              seq_out_reg, seq_out_next;
    logic [CNT_W-1:0]  len_reg, len_next;

    logic              out_free;
    logic              emit;
    logic              have_d;
    logic [7:0]        d_byte;
    logic              bad_code;
    err_t              err_close;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && out_free;

    // Destuff the current data word
    always_comb begin
        have_d   = 1'b0;
        d_byte   = q_token.data;
        bad_code = 1'b0;
        if (esc_pend_reg) begin
            if (q_token.is_sfc) begin
                have_d = 1'b1;
                d_byte = cfg.flag_byte;
            end else if (q_token.is_sec) begin
                have_d = 1'b1;
                d_byte = cfg.escape_byte;
            end else begin
                bad_code = 1'b1;
            end
        end else if (!q_token.is_esc) begin
            have_d = 1'b1;
        end
        err_close = (err_reg == ERR_NONE && esc_pend_reg) ? ERR_ESC : err_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        if (q_pop) begin
            case (state_reg)
                ST_HUNT: state_next = q_token.is_flag ? ST_FLAG : ST_HUNT;
                ST_FLAG: begin
                    if (q_token.is_flag)      state_next = ST_FLAG;
                    else if (q_token.is_addr) state_next = ST_ADDR;
                    else                      state_next = ST_HUNT;
                end
                ST_ADDR: begin
                    if (q_token.is_flag)                          state_next = ST_FLAG;
                    else if (q_token.is_ctrl0 || q_token.is_ctrl1) state_next = ST_CTRL;
                    else                                          state_next = ST_HUNT;
                end
                ST_CTRL: begin
                    if (q_token.is_flag) begin
                        state_next = ST_FLAG;
                    end else if (seq_reg ? q_token.is_hcs1 : q_token.is_hcs0) begin
                        state_next = ST_DATA;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
                ST_DATA: state_next = q_token.is_flag ? ST_FLAG : ST_DATA;
                default: state_next = ST_HUNT;
            endcase
        end
    end

    // Datapath and result
    always_comb begin
        esc_pend_next   = esc_pend_reg;
        seq_next        = seq_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        xor_next        = xor_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        emit            = 1'b0;
        out_byte_next   = 8'd0;
        kind_next       = KIND_PAYLOAD;
        seq_out_next    = seq_reg;
        len_next        = count_reg;
        if (q_pop) begin
            case (state_reg)
                ST_ADDR: begin
                    if (!q_token.is_flag) begin
                        if (q_token.is_ctrl0)      seq_next = 1'b0;
                        else if (q_token.is_ctrl1) seq_next = 1'b1;
                    end
                end
                ST_CTRL: begin
                    if (!q_token.is_flag && (seq_reg ? q_token.is_hcs1 : q_token.is_hcs0)) begin
                        esc_pend_next   = 1'b0;
                        held_valid_next = 1'b0;
                        held_byte_next  = 8'd0;
                        xor_next        = 8'd0;
                        count_next      = '0;
                        err_next        = ERR_NONE;
                    end
                end
                ST_DATA: begin
                    if (q_token.is_flag) begin
                        emit            = 1'b1;
                        err_next        = err_close;
                        esc_pend_next   = 1'b0;
                        held_valid_next = 1'b0;
                        if (err_close == ERR_ESC) begin
                            kind_next = KIND_ESC_ERR;
                        end else if (err_close == ERR_OVF) begin
                            kind_next = KIND_OVERFLOW;
                        end else if (held_valid_reg && held_byte_reg == xor_reg) begin
                            kind_next = KIND_GOOD;
                        end else begin
                            kind_next = KIND_CHECK_ERR;
                        end
                    end else begin
                        if (esc_pend_reg) begin
                            esc_pend_next = 1'b0;
                        end else if (q_token.is_esc) begin
                            esc_pend_next = 1'b1;
                        end
                        if (bad_code && err_reg == ERR_NONE) begin
                            err_next = ERR_ESC;
                        end
                        if (have_d) begin
                            held_byte_next = d_byte;
                            if (!held_valid_reg) begin
                                held_valid_next = 1'b1;
                            end else if (count_reg < CNT_MAX) begin
                                // release the held word: it is not the check word
                                xor_next      = xor_reg ^ held_byte_reg;
                                count_next    = count_reg + 1'b1;
                                emit          = 1'b1;
                                out_byte_next = held_byte_reg;
                                kind_next     = KIND_PAYLOAD;
                                len_next      = count_reg + 1'b1;
                            end else if (err_reg == ERR_NONE) begin
                                err_next = ERR_OVF;
                            end
                        end
                    end
                end
                default: begin
                    seq_next = seq_reg;
                end
            endcase
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_HUNT;
            esc_pend_reg   <= 1'b0;
            seq_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            err_reg        <= ERR_NONE;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            esc_pend_reg   <= esc_pend_next;
            seq_reg        <= seq_next;
            held_valid_reg <= held_valid_next;
            err_reg        <= err_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_byte_reg <= held_byte_next;
        xor_reg       <= xor_next;
        if (emit) begin
            out_byte_reg <= out_byte_next;
            kind_reg     <= kind_next;
            seq_out_reg  <= seq_out_next;
            len_reg      <= len_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_kind      = kind_reg;
    assign m_seq_bit   = seq_out_reg;
    assign m_frame_len = len_reg;

endmodule
`default_nettype wire

// ===== hdl/ifdd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifdd_checker: port-level checks of the frame receiver
// Watches the result channel for hold, reset and field consistency.
// ----------------------------------------------------------------------------
module ifdd_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [7:0]                   m_out_byte,
    input wire logic [2:0]                   m_kind,
    input wire logic                         m_seq_bit,
    input wire logic [ifdd_pkg::CNT_W-1:0]   m_frame_len
);
    import ifdd_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_kind)
            && $stable(m_seq_bit) && $stable(m_frame_len))
        else $error("result changed while stalled");

    // Nothing presented right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Status results carry a zero data word
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_PAYLOAD |-> m_out_byte == 8'd0)
        else $error("status result with nonzero data");

    // Payload count is within the frame limit and never zero
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_PAYLOAD
            |-> m_frame_len != '0 && m_frame_len <= CNT_W'(MAX_PAYLOAD))
        else $error("payload length out of range");

    // Overflow status only reports a saturated count
    a_ovf_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_OVERFLOW |-> m_frame_len == CNT_W'(MAX_PAYLOAD))
        else $error("overflow status without full count");

endmodule

bind info_frame_deframer_destuffer_core ifdd_checker u_ifdd_checker (.*);
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the information frame deframer/destuffer
// Feeds received line words over the input channel. Each accepted word also
// goes through a bench-side deframer that predicts the payload and status
// words. Every word taken from the result channel is compared with the oldest
// prediction. Both channels idle at random. Register settings change only
// while the receiver is drained.
// ----------------------------------------------------------------------------
module tb;
    import ifdd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    // Idle tail that lets a word with no result clear the token queue and the frame engine.
    localparam int IDLE_TAIL   = 8;
    localparam int SHOW_LIMIT  = 10;

    localparam cfg_t CFG_DEFAULT = '{8'h7E, 8'h7D, 8'h5E, 8'h5D, 8'h03, 8'h00, 8'h40};

    typedef logic [7:0] byte_q_t[$];

    // Ways a generated frame departs from a clean frame.
    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_BAD_CHECK,
        FLAW_BAD_ESCAPE,
        FLAW_ESC_AT_END,
        FLAW_BAD_HEADER,
        FLAW_NO_CHECK
    } frame_flaw_t;

    // One predicted word on the result channel.
    typedef struct packed {
        logic [7:0]       out_byte;
        kind_t            kind;
        logic             seq_bit;
        logic [CNT_W-1:0] frame_len;
    } deframed_t;

    // ------------------------------------------------------------------------
    // Clock, reset and every block input, known from time zero
    // ------------------------------------------------------------------------
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [7:0]         m_out_byte;
    logic [2:0]         m_kind;
    logic               m_seq_bit;
    logic [CNT_W-1:0]   m_frame_len;

    always #5 aclk = ~aclk;

    info_frame_deframer_destuffer_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_seq_bit  (m_seq_bit),
        .m_frame_len(m_frame_len)
    );

    // ------------------------------------------------------------------------
    // Bench-side deframer state and its copy of the register file
    // ------------------------------------------------------------------------
    cfg_t       cfg      = CFG_DEFAULT;
    rx_state_t  rx_state = ST_HUNT;
    logic       esc_pend = 1'b0;
    logic       cur_seq  = 1'b0;
    logic       hold_vld = 1'b0;
    logic [7:0] hold_byte = 8'h00;
    logic [7:0] data_xor = 8'h00;
    int         pay_cnt  = 0;
    err_t       err_lat  = ERR_NONE;

    deframed_t  expected_results[$];

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  status_seen    = 0;
    int  words_sent     = 0;
    int  settings_used  = 0;
    bit  tx_burst       = 1'b0;
    bit  rx_burst       = 1'b0;

    // Keep the first error of a frame.
    function automatic void latch_frame_error(err_t e);
        if (err_lat == ERR_NONE) err_lat = e;
    endfunction

    // Advance the bench deframer by one received word; queue any result it yields.
    task automatic deframe_predict(input logic [7:0] b);
        logic [7:0] d;
        logic [7:0] ctrl;
        bit         have_d;
        kind_t      k;
        have_d = 1'b0;
        d      = 8'h00;
        case (rx_state)
            ST_FLAG: begin
                if (b == cfg.flag_byte) rx_state = ST_FLAG;
                else if (b == cfg.address_byte) rx_state = ST_ADDR;
                else rx_state = ST_HUNT;
            end
            ST_ADDR: begin
                if (b == cfg.flag_byte) begin
                    rx_state = ST_FLAG;
                end else if (b == cfg.control_seq0) begin
                    // seq 0 wins when both control codes match
                    cur_seq  = 1'b0;
                    rx_state = ST_CTRL;
                end else if (b == cfg.control_seq1) begin
                    cur_seq  = 1'b1;
                    rx_state = ST_CTRL;
                end else begin
                    rx_state = ST_HUNT;
                end
            end
            ST_CTRL: begin
                ctrl = cur_seq ? cfg.control_seq1 : cfg.control_seq0;
                if (b == cfg.flag_byte) begin
                    rx_state = ST_FLAG;
                end else if (b == (cfg.address_byte ^ ctrl)) begin
                    // header accepted: open a fresh frame
                    rx_state  = ST_DATA;
                    esc_pend  = 1'b0;
                    hold_vld  = 1'b0;
                    hold_byte = 8'h00;
                    data_xor  = 8'h00;
                    pay_cnt   = 0;
                    err_lat   = ERR_NONE;
                end else begin
                    rx_state = ST_HUNT;
                end
            end
            ST_DATA: begin
                if (b == cfg.flag_byte) begin
                    // closing flag: report status, then let it open the next frame
                    if (esc_pend) latch_frame_error(ERR_ESC);
                    if (err_lat == ERR_ESC) k = KIND_ESC_ERR;
                    else if (err_lat == ERR_OVF) k = KIND_OVERFLOW;
                    else if (hold_vld && hold_byte == data_xor) k = KIND_GOOD;
                    else k = KIND_CHECK_ERR;
                    expected_results.push_back('{out_byte: 8'h00, kind: k, seq_bit: cur_seq,
                                                 frame_len: pay_cnt[CNT_W-1:0]});
                    esc_pend = 1'b0;
                    hold_vld = 1'b0;
                    rx_state = ST_FLAG;
                end else if (esc_pend) begin
                    esc_pend = 1'b0;
                    if (b == cfg.stuffed_flag_code) begin
                        d = cfg.flag_byte;
                        have_d = 1'b1;
                    end else if (b == cfg.stuffed_escape_code) begin
                        d = cfg.escape_byte;
                        have_d = 1'b1;
                    end else begin
                        latch_frame_error(ERR_ESC);
                    end
                end else if (b == cfg.escape_byte) begin
                    esc_pend = 1'b1;
                end else begin
                    d = b;
                    have_d = 1'b1;
                end
                // Release the held word once a newer one arrives; the last one is the check.
                if (have_d) begin
                    if (hold_vld) begin
                        if (pay_cnt < MAX_PAYLOAD) begin
                            data_xor = data_xor ^ hold_byte;
                            pay_cnt++;
                            expected_results.push_back('{out_byte: hold_byte, kind: KIND_PAYLOAD,
                                                         seq_bit: cur_seq,
                                                         frame_len: pay_cnt[CNT_W-1:0]});
                        end else begin
                            latch_frame_error(ERR_OVF);
                        end
                    end
                    hold_byte = d;
                    hold_vld  = 1'b1;
                end
            end
            default: begin
                if (b == cfg.flag_byte) rx_state = ST_FLAG;
                else rx_state = ST_HUNT;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Input side: one word per call, random gap first, predict on acceptance
    // ------------------------------------------------------------------------
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        // Drop valid only across a real gap, so it never falls and rises in one step.
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        deframe_predict(b);
        words_sent++;
    endtask

    // Payload with a fair share of flag and escape values, so stuffing happens often.
    function automatic byte_q_t random_payload(input int len);
        byte_q_t q;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0:       q.push_back(cfg.flag_byte);
                1:       q.push_back(cfg.escape_byte);
                default: q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        return q;
    endfunction

    // Build one stuffed information frame under the current settings and send it.
    task automatic send_frame(input logic seq, input byte_q_t payload,
                              input frame_flaw_t flaw, input bit open_flag);
        byte_q_t    raw;
        logic [7:0] ctrl;
        logic [7:0] chk;
        logic [7:0] d;
        logic [7:0] odd;
        int         bad_at;
        ctrl   = seq ? cfg.control_seq1 : cfg.control_seq0;
        chk    = 8'h00;
        bad_at = (flaw == FLAW_BAD_ESCAPE) ? int'($urandom_range(0, payload.size())) : -1;
        if (open_flag) raw.push_back(cfg.flag_byte);
        raw.push_back(cfg.address_byte);
        raw.push_back(ctrl);
        if (flaw == FLAW_BAD_HEADER)
            raw.push_back(cfg.address_byte ^ ctrl ^ 8'($urandom_range(1, 255)));
        else
            raw.push_back(cfg.address_byte ^ ctrl);
        // Walk the payload, then the check word at index size().
        for (int i = 0; i <= payload.size(); i++) begin
            if (i == bad_at) begin
                do odd = 8'($urandom_range(0, 255));
                while (odd == cfg.stuffed_flag_code || odd == cfg.stuffed_escape_code ||
                       odd == cfg.flag_byte);
                raw.push_back(cfg.escape_byte);
                raw.push_back(odd);
            end
            if (i < payload.size()) begin
                d   = payload[i];
                chk = chk ^ d;
            end else if (flaw == FLAW_BAD_CHECK) begin
                d = chk ^ 8'($urandom_range(1, 255));
            end else begin
                d = chk;
            end
            if (i < payload.size() || flaw != FLAW_NO_CHECK) begin
                if (d == cfg.flag_byte) begin
                    raw.push_back(cfg.escape_byte);
                    raw.push_back(cfg.stuffed_flag_code);
                end else if (d == cfg.escape_byte) begin
                    raw.push_back(cfg.escape_byte);
                    raw.push_back(cfg.stuffed_escape_code);
                end else begin
                    raw.push_back(d);
                end
            end
        end
        if (flaw == FLAW_ESC_AT_END) raw.push_back(cfg.escape_byte);
        raw.push_back(cfg.flag_byte);
        foreach (raw[i]) send_rx_byte(raw[i]);
    endtask

    // Hold the input idle until every prediction has come out and the core is empty.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (IDLE_TAIL) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Register writes: setup cycle, then access cycle; pready is always high
    // ------------------------------------------------------------------------
    task automatic apb_write(input reg_idx_t idx, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    // Write all seven registers back to back; call only while drained.
    task automatic write_all(input cfg_t c);
        apb_write(REG_FLAG,      c.flag_byte);
        apb_write(REG_ESCAPE,    c.escape_byte);
        apb_write(REG_STUFF_FLG, c.stuffed_flag_code);
        apb_write(REG_STUFF_ESC, c.stuffed_escape_code);
        apb_write(REG_ADDRESS,   c.address_byte);
        apb_write(REG_CTRL0,     c.control_seq0);
        apb_write(REG_CTRL1,     c.control_seq1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg = c;
        settings_used++;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Clean frames under the reset settings: stuffing, extreme data values,
    // check-only frame and a frame that closes without a check word.
    task automatic test_basic_frames();
        send_frame(1'b0, '{8'h00, 8'hFF, cfg.flag_byte, cfg.escape_byte}, FLAW_NONE, 1'b1);
        send_frame(1'b1, random_payload(0), FLAW_NONE, 1'b0);
        send_frame(1'b0, random_payload(0), FLAW_NO_CHECK, 1'b0);
    endtask

    // Flags inside the header restart the hunt; a broken header is skipped.
    task automatic test_header_resync();
        send_rx_byte(cfg.address_byte);
        send_rx_byte(cfg.flag_byte);
        send_rx_byte(cfg.address_byte);
        send_rx_byte(cfg.control_seq0);
        send_rx_byte(cfg.flag_byte);
        send_frame(1'b1, random_payload(2), FLAW_NONE, 1'b0);
        send_frame(1'b0, random_payload(1), FLAW_BAD_HEADER, 1'b0);
        send_frame(1'b0, random_payload(1), FLAW_NONE, 1'b0);
    endtask

    // Unknown stuffed code, escape right before the flag, and a wrong check word.
    task automatic test_frame_errors();
        send_frame(1'b1, random_payload(2), FLAW_BAD_ESCAPE, 1'b0);
        send_frame(1'b0, random_payload(1), FLAW_ESC_AT_END, 1'b0);
        send_frame(1'b1, random_payload(2), FLAW_BAD_CHECK, 1'b0);
    endtask

    // Both control codes equal: the frame must come out as sequence 0.
    task automatic test_equal_controls();
        cfg_t c;
        c = CFG_DEFAULT;
        c.control_seq0        = 8'hFF;
        c.control_seq1        = 8'hFF;
        c.stuffed_escape_code = 8'h00;
        wait_idle();
        write_all(c);
        send_frame(1'b1, random_payload(2), FLAW_NONE, 1'b1);
    endtask

    // Mostly well-formed frames with random content and flaws, some noise,
    // over several register settings including the extremes.
    task automatic test_random_traffic();
        cfg_t        c;
        frame_flaw_t flaw;
        int          phase_end;
        int          len;
        for (int s = 0; s < 6; s++) begin
            case (s)
                0: c = CFG_DEFAULT;
                1: c = '{flag_byte: 8'h00, escape_byte: 8'hFF, stuffed_flag_code: 8'hFF,
                         stuffed_escape_code: 8'h01, address_byte: 8'hFF,
                         control_seq0: 8'h01, control_seq1: 8'h80};
                2: c = '{flag_byte: 8'hFF, escape_byte: 8'h00, stuffed_flag_code: 8'h00,
                         stuffed_escape_code: 8'hFE, address_byte: 8'h00,
                         control_seq0: 8'h7F, control_seq1: 8'h00};
                3: c = '{flag_byte: 8'h7E, escape_byte: 8'h7D, stuffed_flag_code: 8'h00,
                         stuffed_escape_code: 8'hFF, address_byte: 8'h00,
                         control_seq0: 8'hFF, control_seq1: 8'h01};
                default: begin
                    c.flag_byte = 8'($urandom_range(0, 255));
                    do c.escape_byte = 8'($urandom_range(0, 255));
                    while (c.escape_byte == c.flag_byte);
                    c.stuffed_flag_code = 8'($urandom_range(0, 255));
                    do c.stuffed_escape_code = 8'($urandom_range(0, 255));
                    while (c.stuffed_escape_code == c.stuffed_flag_code);
                    c.address_byte = 8'($urandom_range(0, 255));
                    c.control_seq0 = 8'($urandom_range(0, 255));
                    c.control_seq1 = 8'($urandom_range(0, 255));
                end
            endcase
            wait_idle();
            write_all(c);
            phase_end = words_sent + 140;
            while (words_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom_range(0, 255)));
                    1: send_rx_byte(cfg.flag_byte);
                    default: begin
                        case ($urandom_range(0, 9))
                            0:       flaw = FLAW_BAD_CHECK;
                            1:       flaw = FLAW_BAD_ESCAPE;
                            2:       flaw = FLAW_ESC_AT_END;
                            3:       flaw = FLAW_BAD_HEADER;
                            4:       flaw = FLAW_NO_CHECK;
                            default: flaw = FLAW_NONE;
                        endcase
                        // keep frames short, with an occasional longer one
                        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60)
                                                           : $urandom_range(0, 12);
                        send_frame(1'($urandom_range(0, 1)), random_payload(len), flaw,
                                   1'($urandom_range(0, 1)));
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, compare each word with the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT) $display("MISMATCH %s", msg);
    endfunction

    initial begin : result_checker
        int        stall;
        deframed_t want;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 47) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            results_seen++;
            if (m_kind != KIND_PAYLOAD) status_seen++;
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected word: byte %02h kind %0d seq %0d len %0d",
                                        m_out_byte, m_kind, m_seq_bit, m_frame_len));
            end else begin
                want = expected_results.pop_front();
                if (m_out_byte !== want.out_byte || m_kind !== want.kind ||
                    m_seq_bit !== want.seq_bit || m_frame_len !== want.frame_len)
                    note_mismatch($sformatf({"word %0d: expected byte %02h kind %0d seq %0d ",
                                             "len %0d, got byte %02h kind %0d seq %0d len %0d"},
                                            results_seen, want.out_byte, want.kind,
                                            want.seq_bit, want.frame_len, m_out_byte, m_kind,
                                            m_seq_bit, m_frame_len));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if the traffic never drains
    // ------------------------------------------------------------------------
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles, %0d words still expected",
                 cycle_count, expected_results.size());
        $display("FAIL info_frame_deframer_destuffer_core");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : run_tests
        // hold reset low from time zero, then release at an edge
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_frames();
        test_header_resync();
        test_frame_errors();
        test_equal_controls();
        test_random_traffic();
        wait_idle();
        $display("Sent %0d line words under %0d register settings; checked %0d results",
                 words_sent, settings_used, results_seen);
        $display("(%0d frame status words), %0d mismatches", status_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS info_frame_deframer_destuffer_core");
        end else begin
            $display("FAIL info_frame_deframer_destuffer_core");
        end
        $finish;
    end

endmodule
